@@ rtl/gmp_pkg.sv @@
// ============================================================================
// gmp_pkg - shared definitions of the greedy meshlet packer
// Widths, result kinds, configuration indexes and the structs that travel
// between the slot cells, the resolve stage and the result emitter.
// ============================================================================
package gmp_pkg;

  // Sizes of the open meshlet
  localparam int MAX_SLOTS = 64;
  localparam int MAX_TRIS  = 124;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int TRI_W     = $clog2(MAX_TRIS + 1);

  // Field widths of the stream payloads
  localparam int VTX_W     = 32;
  localparam int LOC_W     = 6;
  localparam int TOT_W     = 7;
  localparam int KIND_W    = 2;
  localparam int IN_DATA_W = 3 * VTX_W;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_LIMIT = 1'd1;
  localparam int MIN_VERTEX_LIMIT = 3;
  localparam int MIN_TRI_LIMIT    = 1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DESC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRI    = 2'd2;

  // Result slots of one triangle, in emission order
  localparam int NRES   = 6;
  localparam int B_PRE  = 0;
  localparam int B_VA   = 1;
  localparam int B_VB   = 2;
  localparam int B_VC   = 3;
  localparam int B_TRI  = 4;
  localparam int B_POST = 5;

  // Lookup result carried along the cell chain
  typedef struct packed {
    logic [2:0]             found;
    logic [2:0][SLOT_W-1:0] idx;
  } gmp_hit_t;

  // One slot write
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [VTX_W-1:0]  data;
  } gmp_wr_t;

  // Meshlet descriptor
  typedef struct packed {
    logic [31:0]      cluster_number;
    logic [31:0]      vert_base;
    logic [TOT_W-1:0] vertex_total;
    logic [31:0]      prim_offset;
    logic [TOT_W-1:0] triangle_total;
  } gmp_desc_t;

  // All results of one triangle, waiting to be emitted
  typedef struct packed {
    gmp_desc_t             pre;
    gmp_desc_t             post;
    logic [2:0][VTX_W-1:0] vtx;
    logic [2:0][LOC_W-1:0] loc;
  } gmp_batch_t;

  // Result tdata layout, last member in the lowest bits
  typedef struct packed {
    logic [TOT_W-1:0] triangle_total;
    logic [31:0]      prim_offset;
    logic [TOT_W-1:0] vertex_total;
    logic [31:0]      vert_base;
    logic [31:0]      cluster_number;
    logic [LOC_W-1:0] local_c;
    logic [LOC_W-1:0] local_b;
    logic [LOC_W-1:0] local_a;
    logic [VTX_W-1:0] global_vertex;
  } gmp_odata_t;

  localparam int OUT_DATA_W = $bits(gmp_odata_t);

endpackage

@@ rtl/greedy_meshlet_packer_core.sv @@
// ============================================================================
// greedy_meshlet_packer_core - greedy meshlet packer
// Packs a stream of triangles into meshlets and streams out descriptors,
// appended vertices and local triangle indices.
// ============================================================================
// One triangle per input transaction. The open meshlet's vertices sit in a
// row of 64 slot cells; a triangle passes through lookup, where every
// cell compares its vertex against the three inputs, and then through
// resolve, where the hit record from the end of the cell chain decides on a
// descriptor, appends new vertices and updates the counters. Since the next
// lookup must see the slots that resolve writes, a triangle moves from
// lookup to resolve only while resolve is empty. Each triangle gives 1 to 6
// results, sent one per cycle while the output is not stalled, from a
// registered output stage. Limits are read clamped to 3..64 vertices and
// 1..124 triangles; write them only while the block is idle. No clearing
// pass is needed after reset.
// ============================================================================
module greedy_meshlet_packer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration writes
  input  logic                                  cfg_we,
  input  logic [gmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gmp_pkg::CFG_W-1:0]             cfg_data,
  // Triangles in
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: vertex_a, vertex_b, vertex_c; tlast: final_triangle
  input  logic [gmp_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                  in_tlast,
  // Results out
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata: global_vertex, local_a, local_b, local_c, cluster_number,
  //        vert_base, vertex_total, prim_offset, triangle_total
  output logic [gmp_pkg::OUT_DATA_W-1:0]        out_tdata,
  // tuser: kind; tlast: run_end
  output logic [gmp_pkg::KIND_W-1:0]            out_tuser,
  output logic                                  out_tlast
);
  import gmp_pkg::*;

  // Triple of a triangle count, as prim indices
  function automatic logic [TRI_W+1:0] tri3(input logic [TRI_W-1:0] t);
    tri3 = ({2'b00, t} << 1) + {2'b00, t};
  endfunction

  // Limit registers
  logic [CFG_W-1:0] vlim_r;
  logic [CFG_W-1:0] tlim_r;

  // Lookup and resolve stages
  logic                  s1_v_r, s1_v_nxt;
  logic [2:0][VTX_W-1:0] s1_vtx_r;
  logic                  s1_fin_r;
  logic                  s2_v_r, s2_v_nxt;
  logic [2:0][VTX_W-1:0] s2_vtx_r;
  logic                  s2_fin_r;

  // Open meshlet and running counters
  logic [CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [TRI_W-1:0] tris_used_r, tris_used_nxt;
  logic [31:0]      vtx_em_r, vtx_em_nxt;
  logic [31:0]      prim_em_r, prim_em_nxt;
  logic [31:0]      mesh_em_r, mesh_em_nxt;

  logic in_acc;
  logic move;
  logic resolve;
  logic can_load;

  gmp_hit_t hit [MAX_SLOTS+1];
  gmp_hit_t hits;
  gmp_wr_t [2:0] wr;

  logic [CNT_W-1:0] vl_c;
  logic [TRI_W-1:0] tl_c;
  logic [1:0]       fresh;
  logic [CNT_W:0]   sum_v;
  logic             fits;
  logic             close_pre;
  logic             fin;
  logic [2:0]       eff_found;
  logic             eq_ab, eq_ac, eq_bc;
  logic             add_a, add_b, add_c;
  logic [CNT_W-1:0] base, pos_b, pos_c, slots_new;
  logic [SLOT_W-1:0] loc_a, loc_b, loc_c;
  logic [TRI_W-1:0] tris_new;
  logic [CNT_W-1:0] vinc_pre, vinc_post;
  logic [TRI_W+1:0] pinc_pre, pinc_post;
  logic [31:0]      vtx_mid, prim_mid, mesh_mid;
  logic [NRES-1:0]  res_mask;
  gmp_batch_t       batch;

  // Stage handshakes: lookup only while resolve is empty, so it sees the
  // slots as left by the previous triangle
  assign in_tready = !s1_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign move      = s1_v_r && !s2_v_r;
  assign resolve   = s2_v_r && can_load;
  assign s1_v_nxt  = in_acc || (s1_v_r && !move);
  assign s2_v_nxt  = move || (s2_v_r && !resolve);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r       <= CFG_W'(MAX_SLOTS);
      tlim_r       <= CFG_W'(MAX_TRIS);
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      slots_used_r <= '0;
      tris_used_r  <= '0;
      vtx_em_r     <= '0;
      prim_em_r    <= '0;
      mesh_em_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_LIMIT:   vlim_r <= cfg_data;
          CFG_TRIANGLE_LIMIT: tlim_r <= cfg_data;
          default: ;
        endcase
      end
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      slots_used_r <= slots_used_nxt;
      tris_used_r  <= tris_used_nxt;
      vtx_em_r     <= vtx_em_nxt;
      prim_em_r    <= prim_em_nxt;
      mesh_em_r    <= mesh_em_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_vtx_r[0] <= in_tdata[VTX_W-1:0];
      s1_vtx_r[1] <= in_tdata[2*VTX_W-1:VTX_W];
      s1_vtx_r[2] <= in_tdata[3*VTX_W-1:2*VTX_W];
      s1_fin_r    <= in_tlast;
    end
    if (move) begin
      s2_vtx_r <= s1_vtx_r;
      s2_fin_r <= s1_fin_r;
    end
  end

  // Row of slot cells, hit record passed cell to cell
  assign hit[0] = '0;
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
    gmp_cell u_slot (
      .clk        (clk),
      .cell_idx   (SLOT_W'(g)),
      .slots_used (slots_used_r),
      .query      (s1_vtx_r),
      .capture    (move),
      .wr         (wr),
      .hit_in     (hit[g]),
      .hit_out    (hit[g+1])
    );
  end
  assign hits = hit[MAX_SLOTS];

  // Clamp the limits
  always_comb begin
    vl_c = CNT_W'(vlim_r);
    if (vlim_r < CFG_W'(MIN_VERTEX_LIMIT)) begin
      vl_c = CNT_W'(MIN_VERTEX_LIMIT);
    end else if (CNT_W'(vlim_r) > CNT_W'(MAX_SLOTS)) begin
      vl_c = CNT_W'(MAX_SLOTS);
    end
    tl_c = TRI_W'(tlim_r);
    if (tlim_r < CFG_W'(MIN_TRI_LIMIT)) begin
      tl_c = TRI_W'(MIN_TRI_LIMIT);
    end else if (TRI_W'(tlim_r) > TRI_W'(MAX_TRIS)) begin
      tl_c = TRI_W'(MAX_TRIS);
    end
  end

  // Fit test against the store as it was before the triangle
  assign fresh = {1'b0, ~hits.found[0]} + {1'b0, ~hits.found[1]}
               + {1'b0, ~hits.found[2]};
  assign sum_v     = {1'b0, slots_used_r} + (CNT_W+1)'(fresh);
  assign fits      = (sum_v <= {1'b0, vl_c}) && (tris_used_r < tl_c);
  assign close_pre = !fits && (tris_used_r != '0);
  assign fin       = s2_fin_r;

  // A closed meshlet starts empty, so nothing is found any more
  assign eff_found = hits.found & {3{!close_pre}};
  assign eq_ab = (s2_vtx_r[1] == s2_vtx_r[0]);
  assign eq_ac = (s2_vtx_r[2] == s2_vtx_r[0]);
  assign eq_bc = (s2_vtx_r[2] == s2_vtx_r[1]);

  // Appends in a, b, c order, a repeat within the triangle reuses its slot
  assign add_a     = !eff_found[0];
  assign add_b     = !eff_found[1] && !eq_ab;
  assign add_c     = !eff_found[2] && !eq_ac && !eq_bc;
  assign base      = close_pre ? '0 : slots_used_r;
  assign pos_b     = base + CNT_W'(add_a);
  assign pos_c     = pos_b + CNT_W'(add_b);
  assign slots_new = pos_c + CNT_W'(add_c);

  always_comb begin
    loc_a = eff_found[0] ? hits.idx[0] : base[SLOT_W-1:0];
    if (eff_found[1]) begin
      loc_b = hits.idx[1];
    end else if (eq_ab) begin
      loc_b = loc_a;
    end else begin
      loc_b = pos_b[SLOT_W-1:0];
    end
    if (eff_found[2]) begin
      loc_c = hits.idx[2];
    end else if (eq_ac) begin
      loc_c = loc_a;
    end else if (eq_bc) begin
      loc_c = loc_b;
    end else begin
      loc_c = pos_c[SLOT_W-1:0];
    end
  end

  // Slot writes
  always_comb begin
    wr[0].en   = resolve && add_a;
    wr[0].idx  = base[SLOT_W-1:0];
    wr[0].data = s2_vtx_r[0];
    wr[1].en   = resolve && add_b;
    wr[1].idx  = pos_b[SLOT_W-1:0];
    wr[1].data = s2_vtx_r[1];
    wr[2].en   = resolve && add_c;
    wr[2].idx  = pos_c[SLOT_W-1:0];
    wr[2].data = s2_vtx_r[2];
  end

  // Counters after the closes
  assign tris_new  = (close_pre ? '0 : tris_used_r) + TRI_W'(1);
  assign vinc_pre  = close_pre ? slots_used_r : '0;
  assign vinc_post = fin ? slots_new : '0;
  assign pinc_pre  = close_pre ? tri3(tris_used_r) : '0;
  assign pinc_post = fin ? tri3(tris_new) : '0;
  assign vtx_mid   = vtx_em_r + 32'(vinc_pre);
  assign prim_mid  = prim_em_r + 32'(pinc_pre);
  assign mesh_mid  = mesh_em_r + 32'(close_pre);

  always_comb begin
    slots_used_nxt = slots_used_r;
    tris_used_nxt  = tris_used_r;
    vtx_em_nxt     = vtx_em_r;
    prim_em_nxt    = prim_em_r;
    mesh_em_nxt    = mesh_em_r;
    if (resolve) begin
      slots_used_nxt = fin ? '0 : slots_new;
      tris_used_nxt  = fin ? '0 : tris_new;
      vtx_em_nxt     = vtx_em_r + 32'({1'b0, vinc_pre} + {1'b0, vinc_post});
      prim_em_nxt    = prim_em_r + 32'({1'b0, pinc_pre} + {1'b0, pinc_post});
      mesh_em_nxt    = mesh_em_r + 32'({1'b0, close_pre} + {1'b0, fin});
    end
  end

  // Results of this triangle
  always_comb begin
    res_mask         = '0;
    res_mask[B_PRE]  = close_pre;
    res_mask[B_VA]   = add_a;
    res_mask[B_VB]   = add_b;
    res_mask[B_VC]   = add_c;
    res_mask[B_TRI]  = 1'b1;
    res_mask[B_POST] = fin;

    batch.pre.cluster_number  = mesh_em_r;
    batch.pre.vert_base       = vtx_em_r;
    batch.pre.vertex_total    = TOT_W'(slots_used_r);
    batch.pre.prim_offset     = prim_em_r;
    batch.pre.triangle_total  = TOT_W'(tris_used_r);
    batch.post.cluster_number = mesh_mid;
    batch.post.vert_base      = vtx_mid;
    batch.post.vertex_total   = TOT_W'(slots_new);
    batch.post.prim_offset    = prim_mid;
    batch.post.triangle_total = TOT_W'(tris_new);
    batch.vtx                 = s2_vtx_r;
    batch.loc[0]              = LOC_W'(loc_a);
    batch.loc[1]              = LOC_W'(loc_b);
    batch.loc[2]              = LOC_W'(loc_c);
  end

  gmp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (resolve),
    .load_mask  (res_mask),
    .batch      (batch),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/gmp_cell.sv @@
// ============================================================================
// gmp_cell - one vertex slot of the meshlet store
// Holds one global vertex index, compares it against the three vertices of
// the triangle in lookup, registers the hits and merges them into the hit
// record handed on to the next cell.
// ============================================================================
module gmp_cell (
  input  logic                                  clk,
  input  logic [gmp_pkg::SLOT_W-1:0]            cell_idx,
  input  logic [gmp_pkg::CNT_W-1:0]             slots_used,
  input  logic [2:0][gmp_pkg::VTX_W-1:0]        query,
  input  logic                                  capture,
  input  gmp_pkg::gmp_wr_t [2:0]                wr,
  input  gmp_pkg::gmp_hit_t                     hit_in,
  output gmp_pkg::gmp_hit_t                     hit_out
);
  import gmp_pkg::*;

  logic [VTX_W-1:0] value_r;
  logic [VTX_W-1:0] value_nxt;
  logic [2:0]       match_r;
  logic [2:0]       match_nxt;
  logic             occupied;

  // Slot holds a live vertex only below the fill count
  assign occupied = CNT_W'(cell_idx) < slots_used;

  // Slot write, at most one port addresses this cell
  always_comb begin
    value_nxt = value_r;
    for (int k = 0; k < 3; k++) begin
      if (wr[k].en && (wr[k].idx == cell_idx)) begin
        value_nxt = wr[k].data;
      end
    end
  end

  // Compare against the query triangle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      match_nxt[k] = occupied && (value_r == query[k]);
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (capture) begin
      match_r <= match_nxt;
    end
  end

  // Merge own hits into the record from the previous cell
  always_comb begin
    hit_out = hit_in;
    for (int k = 0; k < 3; k++) begin
      hit_out.found[k] = hit_in.found[k] | match_r[k];
      hit_out.idx[k]   = hit_in.idx[k] | ({SLOT_W{match_r[k]}} & cell_idx);
    end
  end

endmodule

@@ rtl/gmp_emit.sv @@
// ============================================================================
// gmp_emit - result emitter of the meshlet packer
// Holds the results of one triangle with a mask of those still due and sends
// them one per unstalled cycle, in order, through a registered output stage.
// ============================================================================
module gmp_emit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [gmp_pkg::NRES-1:0]              load_mask,
  input  gmp_pkg::gmp_batch_t                   batch,
  output logic                                  can_load,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [gmp_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [gmp_pkg::KIND_W-1:0]            out_tuser,
  output logic                                  out_tlast
);
  import gmp_pkg::*;

  logic [NRES-1:0] mask_r;
  logic [NRES-1:0] mask_nxt;
  gmp_batch_t      batch_r;
  logic [NRES-1:0] sel;
  logic [NRES-1:0] rest;
  logic            pop;
  logic            out_v_r;
  logic            out_v_nxt;
  gmp_odata_t      data_r;
  gmp_odata_t      data_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [KIND_W-1:0] kind_nxt;
  logic            last_r;

  // Lowest pending result goes next
  assign sel      = mask_r & (~mask_r + NRES'(1));
  assign rest     = mask_r & ~sel;
  assign pop      = (mask_r != '0) && (!out_v_r || out_tready);
  assign can_load = (mask_r == '0) || (pop && (rest == '0));

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = load_mask;
    end else if (pop) begin
      mask_nxt = rest;
    end
  end

  // Build the selected result, unused fields stay zero
  always_comb begin
    data_nxt = '0;
    kind_nxt = KIND_DESC;
    if (sel[B_PRE] || sel[B_POST]) begin
      kind_nxt = KIND_DESC;
      if (sel[B_PRE]) begin
        data_nxt.cluster_number = batch_r.pre.cluster_number;
        data_nxt.vert_base      = batch_r.pre.vert_base;
        data_nxt.vertex_total   = batch_r.pre.vertex_total;
        data_nxt.prim_offset    = batch_r.pre.prim_offset;
        data_nxt.triangle_total = batch_r.pre.triangle_total;
      end else begin
        data_nxt.cluster_number = batch_r.post.cluster_number;
        data_nxt.vert_base      = batch_r.post.vert_base;
        data_nxt.vertex_total   = batch_r.post.vertex_total;
        data_nxt.prim_offset    = batch_r.post.prim_offset;
        data_nxt.triangle_total = batch_r.post.triangle_total;
      end
    end else if (sel[B_VA]) begin
      kind_nxt = KIND_VERTEX;
      data_nxt.global_vertex = batch_r.vtx[0];
    end else if (sel[B_VB]) begin
      kind_nxt = KIND_VERTEX;
      data_nxt.global_vertex = batch_r.vtx[1];
    end else if (sel[B_VC]) begin
      kind_nxt = KIND_VERTEX;
      data_nxt.global_vertex = batch_r.vtx[2];
    end else begin
      kind_nxt = KIND_TRI;
      data_nxt.local_a = batch_r.loc[0];
      data_nxt.local_b = batch_r.loc[1];
      data_nxt.local_c = batch_r.loc[2];
    end
  end

  // Output register valid
  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch_r <= batch;
    end
    if (pop) begin
      data_r <= data_nxt;
      kind_r <= kind_nxt;
      last_r <= (rest == '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

@@ rtl/gmp_checker.sv @@
// ============================================================================
// gmp_checker - port checks of the greedy meshlet packer
// Watches the top level's ports and flags broken stream behaviour or
// malformed results; attached to every instance of the top level.
// ============================================================================
module gmp_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [gmp_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  logic [gmp_pkg::KIND_W-1:0]            out_tuser,
  input  logic                                  out_tlast
);
  import gmp_pkg::*;

  // Reset empties the output stage
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A taken triangle blocks the input until lookup has moved on
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("triangles accepted on consecutive cycles");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Vertex results carry nothing but the vertex index
  a_vertex_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_VERTEX) |-> (out_tdata[159:32] == '0))
    else $error("vertex result with stray fields");

  // A closed meshlet is never empty
  a_desc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DESC)
      |-> (out_tdata[120:114] != '0) && (out_tdata[159:153] != '0))
    else $error("empty meshlet descriptor");

endmodule

bind greedy_meshlet_packer_core gmp_checker u_gmp_checker (.*);
